// ===== rtl/bsc_pkg.sv =====
// Package: shared constants, payload structs and controller/datapath link types.
package bsc_pkg;

  localparam int unsigned MaxProcsDef = 8;
  localparam int unsigned MaxResDef   = 4;
  localparam int unsigned AmtW        = 8;
  localparam int unsigned WorkW       = 12;
  localparam logic [WorkW-1:0] WorkMax = 12'hFFF;

  localparam logic [2:0] ReqAlloc = 3'd0;
  localparam logic [2:0] ReqMax   = 3'd1;
  localparam logic [2:0] ReqAvail = 3'd2;
  localparam logic [2:0] ReqCheck = 3'd3;
  localparam logic [2:0] ReqGrant = 3'd4;

  localparam logic [2:0] StLoaded   = 3'd0;
  localparam logic [2:0] StSafe     = 3'd1;
  localparam logic [2:0] StUnsafe   = 3'd2;
  localparam logic [2:0] StExceeds  = 3'd3;
  localparam logic [2:0] StNotAvail = 3'd4;
  localparam logic [2:0] StBadProc  = 3'd5;

  localparam logic CfgNumProcs = 1'b0;
  localparam logic CfgNumRes   = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] proc_id;
    logic [7:0] amt0;
    logic [7:0] amt1;
    logic [7:0] amt2;
    logic [7:0] amt3;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] seq_proc;
    logic       last;
  } out_item_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic latch;      // capture input item
    logic load_row;   // write alloc/max/avail row
    logic grant_chk;  // evaluate request against need and avail
    logic apply;      // apply tentative grant
    logic restore;    // undo tentative grant
    logic init;       // work = avail, clear finish, count, index
    logic step;       // examine current process
    logic emit_init;  // reset output pointer
    logic emit;       // advance output pointer
  } bsc_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic       bad_proc;
    logic       is_grant;
    logic       is_check;
    logic       is_load;
    logic       bad_type;
    logic       exceeds;
    logic       not_avail;
    logic       scan_done;
    logic       safe;
    logic       emit_last;
  } bsc_stat_t;

endpackage

// ===== rtl/bsc_ctrl.sv =====
// Controller state machine sequencing loads, requests, scan and emission.
module bsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bsc_pkg::bsc_stat_t stat,
  output bsc_pkg::bsc_cmd_t  cmd,
  output logic               strobe,
  output logic [2:0]         st_code,
  output logic               st_emit
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DEC    = 8'b0000_0010,
    S_GCHK   = 8'b0000_0100,
    S_INIT   = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_EMIT   = 8'b0010_0000,
    S_RESTOR = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic grant_run, grant_run_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      grant_run <= 1'b0;
    end else begin
      state <= state_next;
      grant_run <= grant_run_next;
    end
  end

  // Sequence the item
  always_comb begin
    state_next = state;
    grant_run_next = grant_run;
    cmd = '0;
    strobe = 1'b0;
    st_code = bsc_pkg::StLoaded;
    st_emit = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        priority if (stat.bad_type) begin
          state_next = S_IDLE;
        end else if (stat.is_check) begin
          grant_run_next = 1'b0;
          state_next = S_INIT;
        end else if (stat.bad_proc) begin
          strobe = 1'b1;
          st_code = bsc_pkg::StBadProc;
          state_next = S_IDLE;
        end else if (stat.is_load) begin
          cmd.load_row = 1'b1;
          strobe = 1'b1;
          st_code = bsc_pkg::StLoaded;
          state_next = S_IDLE;
        end else begin
          cmd.grant_chk = 1'b1;
          state_next = S_GCHK;
        end
      end
      S_GCHK: begin
        priority if (stat.exceeds) begin
          strobe = 1'b1;
          st_code = bsc_pkg::StExceeds;
          state_next = S_IDLE;
        end else if (stat.not_avail) begin
          strobe = 1'b1;
          st_code = bsc_pkg::StNotAvail;
          state_next = S_IDLE;
        end else begin
          cmd.apply = 1'b1;
          grant_run_next = 1'b1;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.emit_init = 1'b1;
          if (stat.safe) begin
            state_next = S_EMIT;
          end else begin
            strobe = 1'b1;
            st_code = bsc_pkg::StUnsafe;
            state_next = S_FIN;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        strobe = 1'b1;
        st_code = bsc_pkg::StSafe;
        st_emit = 1'b1;
        cmd.emit = 1'b1;
        if (stat.emit_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (grant_run) cmd.restore = 1'b1;
        grant_run_next = 1'b0;
        state_next = S_IDLE;
      end
      S_RESTOR: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/bsc_dp.sv =====
// Datapath: tables, work vector, scan counters and safe sequence buffer.
module bsc_dp #(
  parameter int unsigned MAX_PROCS = bsc_pkg::MaxProcsDef,
  parameter int unsigned MAX_RES   = bsc_pkg::MaxResDef
) (
  input  logic               clk,
  input  logic               rst,
  input  bsc_pkg::in_item_t  in_item,
  input  logic [3:0]         num_procs,
  input  logic [2:0]         num_res,
  input  bsc_pkg::bsc_cmd_t  cmd,
  output bsc_pkg::bsc_stat_t stat,
  output logic [2:0]         emit_proc
);

  localparam int unsigned PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned RCW = $clog2(MAX_RES + 1);
  localparam int unsigned AW = bsc_pkg::AmtW;
  localparam int unsigned WW = bsc_pkg::WorkW;

  logic [AW-1:0] alloc_tab [MAX_PROCS][MAX_RES];
  logic [AW-1:0] max_tab   [MAX_PROCS][MAX_RES];
  logic [AW-1:0] avail     [MAX_RES];
  logic [WW-1:0] work      [MAX_RES];
  logic [MAX_PROCS-1:0] finish;
  logic [PW-1:0] seq_buf [MAX_PROCS];

  bsc_pkg::in_item_t item;
  logic [AW-1:0] amt [MAX_RES];
  logic [PW-1:0] idx;
  logic [CW-1:0] pass, count, optr;
  logic          exceeds, not_avail;

  // Clamp configuration
  logic [CW-1:0] np;
  logic [RCW-1:0] nr;
  always_comb begin
    if (num_procs == 4'd0) np = CW'(1);
    else if (32'(num_procs) > MAX_PROCS) np = CW'(MAX_PROCS);
    else np = CW'(num_procs);
    if (num_res == 3'd0) nr = RCW'(1);
    else if (32'(num_res) > MAX_RES) nr = RCW'(MAX_RES);
    else nr = RCW'(num_res);
  end

  // Unpack amounts; types beyond the fourth get zero
  always_comb begin
    for (int j = 0; j < MAX_RES; j++) begin
      unique case (j)
        0: amt[j] = item.amt0;
        1: amt[j] = item.amt1;
        2: amt[j] = item.amt2;
        3: amt[j] = item.amt3;
        default: amt[j] = '0;
      endcase
    end
  end

  logic [PW-1:0] pid;
  logic proc_ok;
  assign proc_ok = ({1'b0, item.proc_id} < 4'(np)) && (32'(item.proc_id) < MAX_PROCS);
  assign pid = PW'(item.proc_id);

  // Compare a request against claim and availability
  logic exceeds_c, not_avail_c;
  always_comb begin
    exceeds_c = 1'b0;
    not_avail_c = 1'b0;
    for (int j = 0; j < MAX_RES; j++) begin
      if (j < 32'(nr)) begin
        if ({1'b0, amt[j]} + {1'b0, alloc_tab[pid][j]} > {1'b0, max_tab[pid][j]})
          exceeds_c = 1'b1;
        if (amt[j] > avail[j]) not_avail_c = 1'b1;
      end
    end
  end

  // Fit test for the current scan process
  logic fits;
  always_comb begin
    fits = 1'b1;
    for (int j = 0; j < MAX_RES; j++) begin
      if (j < 32'(nr) && max_tab[idx][j] > alloc_tab[idx][j] &&
          WW'(max_tab[idx][j] - alloc_tab[idx][j]) > work[j])
        fits = 1'b0;
    end
  end

  logic take;
  assign take = cmd.step && !finish[idx] && fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PROCS; i++)
        for (int j = 0; j < MAX_RES; j++) begin
          alloc_tab[i][j] <= '0;
          max_tab[i][j] <= '0;
        end
      for (int j = 0; j < MAX_RES; j++) begin
        avail[j] <= '0;
        work[j] <= '0;
      end
      finish <= '0;
      idx <= '0;
      pass <= '0;
      count <= '0;
      optr <= '0;
      exceeds <= 1'b0;
      not_avail <= 1'b0;
    end else begin
      if (cmd.latch) item <= in_item;
      // Write one row
      if (cmd.load_row) begin
        for (int j = 0; j < MAX_RES; j++) begin
          unique case (item.req_type)
            bsc_pkg::ReqAlloc: alloc_tab[pid][j] <= amt[j];
            bsc_pkg::ReqMax:   max_tab[pid][j] <= amt[j];
            default:           avail[j] <= amt[j];
          endcase
        end
      end
      // Evaluate request
      if (cmd.grant_chk) begin
        exceeds <= exceeds_c;
        not_avail <= not_avail_c;
      end
      // Tentative grant and its undo
      if (cmd.apply || cmd.restore) begin
        for (int j = 0; j < MAX_RES; j++) begin
          if (j < 32'(nr)) begin
            if (cmd.apply) begin
              avail[j] <= avail[j] - amt[j];
              alloc_tab[pid][j] <= alloc_tab[pid][j] + amt[j];
            end else begin
              avail[j] <= avail[j] + amt[j];
              alloc_tab[pid][j] <= alloc_tab[pid][j] - amt[j];
            end
          end
        end
      end
      // Start scan
      if (cmd.init) begin
        for (int j = 0; j < MAX_RES; j++) work[j] <= WW'(avail[j]);
        finish <= '0;
        idx <= '0;
        pass <= '0;
        count <= '0;
      end
      // Advance scan one process
      if (cmd.step) begin
        if (take) begin
          seq_buf[count[PW-1:0]] <= idx;
          count <= count + 1'b1;
          finish[idx] <= 1'b1;
          for (int j = 0; j < MAX_RES; j++) begin
            if (j < 32'(nr)) begin
              if ((WW+1)'(work[j]) + (WW+1)'(alloc_tab[idx][j]) > (WW+1)'(bsc_pkg::WorkMax))
                work[j] <= bsc_pkg::WorkMax;
              else
                work[j] <= work[j] + WW'(alloc_tab[idx][j]);
            end
          end
        end
        if (CW'(idx) + 1'b1 == np) begin
          idx <= '0;
          pass <= pass + 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.emit_init) optr <= '0;
      if (cmd.emit) optr <= optr + 1'b1;
    end
  end

  assign emit_proc = 3'(seq_buf[optr[PW-1:0]]);

  always_comb begin
    stat.bad_type  = item.req_type > bsc_pkg::ReqGrant;
    stat.is_check  = item.req_type == bsc_pkg::ReqCheck;
    stat.is_load   = item.req_type == bsc_pkg::ReqAlloc || item.req_type == bsc_pkg::ReqMax ||
                     item.req_type == bsc_pkg::ReqAvail;
    stat.is_grant  = item.req_type == bsc_pkg::ReqGrant;
    stat.bad_proc  = !proc_ok && item.req_type != bsc_pkg::ReqAvail;
    stat.exceeds   = exceeds;
    stat.not_avail = not_avail;
    stat.scan_done = (pass == np) || (count == np);
    stat.safe      = count == np;
    stat.emit_last = optr + 1'b1 == np;
  end

endmodule

// ===== rtl/bankers_safety_check.sv =====
// Top level: safety and request checker with config registers.
// Each start item is taken while busy is low. Loads and refused requests
// give one result, registered from the decode state (loads, bad process)
// or from the grant-check state (refused requests); a safety check or a
// granted request passes through an init state, then scans one process per
// cycle over up to num_procs passes (ending early once all processes
// finish), then emits the safe sequence one process per cycle with last on
// the final one, or gives one unsafe result when no safe sequence exists. Unknown
// request types give no result. Results appear on result for one cycle
// with result_valid high; the receiver cannot stall them.
module bankers_safety_check #(
  parameter int unsigned MAX_PROCS = bsc_pkg::MaxProcsDef,
  parameter int unsigned MAX_RES   = bsc_pkg::MaxResDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bsc_pkg::in_item_t in_item,
  output logic              result_valid,
  output bsc_pkg::out_item_t result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data
);

  logic [3:0] num_procs;
  logic [2:0] num_res;
  bsc_pkg::bsc_cmd_t  cmd;
  bsc_pkg::bsc_stat_t stat;
  logic strobe, st_emit;
  logic [2:0] st_code, emit_proc;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_procs <= 4'd8;
      num_res <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsc_pkg::CfgNumProcs: num_procs <= cfg_data;
        bsc_pkg::CfgNumRes:   num_res <= cfg_data[2:0];
      endcase
    end
  end

  bsc_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .stat, .cmd, .strobe, .st_code, .st_emit
  );

  bsc_dp #(.MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES)) u_dp (
    .clk, .rst, .in_item, .num_procs, .num_res, .cmd, .stat, .emit_proc
  );

  // Register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= strobe;
    end
    result.status   <= st_code;
    result.seq_proc <= st_emit ? emit_proc : 3'd0;
    result.last     <= st_emit ? stat.emit_last : 1'b1;
  end

endmodule
